>>> rtl/xtw_pkg.sv
// ----------------------------------------------------------------------------
// xtw_pkg: shared types and constants of the two-word XXTEA cipher
// Round count, key reset values, round sum constants and the item record
// that travels along the chain of round cells.
// ----------------------------------------------------------------------------
`default_nettype none

package xtw_pkg;

  // number of full rounds; each round is two half-round cells
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned NCELLS = 2 * ROUNDS;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);

  // golden-ratio step of the round sum
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;
  // first sum of a decryption: ROUNDS * DELTA modulo 2^32
  localparam logic [WORD_W-1:0] DEC_SUM_INIT =
    WORD_W'(64'(ROUNDS) * 64'(DELTA));

  // key reset values
  localparam logic [WORD_W-1:0] KEY0_RST = 32'h4D62_5165;
  localparam logic [WORD_W-1:0] KEY1_RST = 32'h5468_576D;
  localparam logic [WORD_W-1:0] KEY2_RST = 32'h5971_3374;
  localparam logic [WORD_W-1:0] KEY3_RST = 32'h3677_397A;

  // operation codes
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // one block in flight
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/xxtea_two_word_cipher.sv
// ----------------------------------------------------------------------------
// xxtea_two_word_cipher: pipelined two-word XXTEA cipher
// Usage:
//   Send a 64-bit block on the s_axis channel: tdata holds word_lo in the low
//   half and word_hi in the high half, tuser holds op (0 encrypt, 1 decrypt).
//   The transformed block leaves on m_axis with out_lo low and out_hi high.
//   The key sits in four 32-bit APB registers at byte addresses 0, 4, 8, 12;
//   write it only while no block is in flight.
// Timing:
//   A chain of 2*ROUNDS half-round cells (64 for 32 rounds) feeds one output
//   register, and one block is taken every cycle while the chain is not held,
//   since each cell then passes its item to the next on every edge.
// Reset:
//   Clears every item in flight and loads the built-in key.
// Stall:
//   A stalled receiver leaves the result in the output register; one more
//   block is caught by a skid stage, after which the whole cell chain holds
//   and s_axis_tready drops until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

module xxtea_two_word_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // block input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // word_lo [31:0], word_hi [63:32]
  input  wire logic [0:0]  s_axis_tuser,   // op [0]
  // block output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // out_lo [31:0], out_hi [63:32]
  // key registers
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import xtw_pkg::*;

  key_t  key;
  logic  en;
  logic  cell_valid [NCELLS+1];
  item_t cell_item  [NCELLS+1];

  xtw_key_regs u_key_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  // form the entering item with its first round sum
  assign cell_valid[0]    = s_axis_tvalid;
  assign cell_item[0].op  = s_axis_tuser[0];
  assign cell_item[0].v0  = s_axis_tdata[31:0];
  assign cell_item[0].v1  = s_axis_tdata[63:32];
  assign cell_item[0].sum = (s_axis_tuser[0] == OP_DEC) ? DEC_SUM_INIT : DELTA;

  // chain of half-round cells
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    xtw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .half_i  (1'(k % 2)),
      .key_i   (key),
      .valid_i (cell_valid[k]),
      .item_i  (cell_item[k]),
      .valid_o (cell_valid[k+1]),
      .item_o  (cell_item[k+1])
    );
  end

  xtw_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (cell_valid[NCELLS]),
    .data_i        ({cell_item[NCELLS].v1, cell_item[NCELLS].v0}),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign s_axis_tready = en;

`ifndef SYNTHESIS
  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> cell_valid[NCELLS] == $past(cell_valid[NCELLS]))
    else $error("cell chain moved while frozen");

  a_first_cell_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> cell_valid[1])
    else $error("accepted item missing from first cell");

  a_hold_when_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> cell_valid[1] == $past(cell_valid[1]))
    else $error("first cell changed while frozen");
`endif

endmodule

`default_nettype wire

>>> rtl/xtw_key_regs.sv
// ----------------------------------------------------------------------------
// xtw_key_regs: key register file
// Four 32-bit key words behind an APB-style port, reset to the built-in key.
// ----------------------------------------------------------------------------
`default_nettype none

module xtw_key_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output xtw_pkg::key_t              key_o
);
  import xtw_pkg::*;

  key_t                 key_q, key_d;
  logic [KEY_IDX_W-1:0] idx;
  logic                 wr_en;

  // decode the word address and the write strobe
  always_comb begin
    pready = 1'b1;
    idx    = paddr[3:2];
    wr_en  = psel & penable & pwrite & pready;
    prdata = key_q[idx];
    key_d  = key_q;
    if (wr_en) begin
      key_d[idx] = pwdata;
    end
  end

  // hold the key words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KEY0_RST;
      key_q[1] <= KEY1_RST;
      key_q[2] <= KEY2_RST;
      key_q[3] <= KEY3_RST;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

>>> rtl/xtw_cell.sv
// ----------------------------------------------------------------------------
// xtw_cell: half-round cell
// Updates one word of the block with the MX mix of the other word, then
// registers the item for the next cell. The second half of a round also
// steps the round sum.
// ----------------------------------------------------------------------------
`default_nettype none

module xtw_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           half_i,
  input  wire xtw_pkg::key_t  key_i,
  input  wire logic           valid_i,
  input  wire xtw_pkg::item_t item_i,
  output logic                valid_o,
  output xtw_pkg::item_t      item_o
);
  import xtw_pkg::*;

  logic                 upd_hi;
  logic [WORD_W-1:0]    y, w, w_new, mix_a, mix_b, mx;
  logic [KEY_IDX_W-1:0] k_idx;
  logic                 valid_q;
  item_t                item_q, item_d;

  // pick the word to update and mix the other one into it
  always_comb begin
    upd_hi = half_i ^ item_i.op;
    y      = upd_hi ? item_i.v0 : item_i.v1;
    w      = upd_hi ? item_i.v1 : item_i.v0;
    k_idx  = item_i.sum[3:2] ^ {1'b0, upd_hi};
    mix_a  = ((y >> 5) ^ (y << 2)) + ((y >> 3) ^ (y << 4));
    mix_b  = (item_i.sum ^ y) + (key_i[k_idx] ^ y);
    mx     = mix_a ^ mix_b;
    w_new  = (item_i.op == OP_DEC) ? (w - mx) : (w + mx);

    item_d = item_i;
    if (upd_hi) begin
      item_d.v1 = w_new;
    end else begin
      item_d.v0 = w_new;
    end
    // advance the sum at the end of a round
    if (half_i) begin
      item_d.sum = (item_i.op == OP_DEC) ? (item_i.sum - DELTA) : (item_i.sum + DELTA);
    end
  end

  // hand the item on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/xtw_out_buf.sv
// ----------------------------------------------------------------------------
// xtw_out_buf: output register with skid stage
// Holds a finished block for the receiver and catches one more when the
// receiver stalls; the cell chain freezes only while the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module xtw_out_buf (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [63:0] data_i,
  output logic             en_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata
);

  logic        out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic        load_out, load_skid, drain;
  logic [63:0] out_q, skid_q;

  // steer the arriving item into the output or the skid stage
  always_comb begin
    en_o      = !skid_v_q;
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_out  = 1'b0;
    load_skid = 1'b0;
    drain     = 1'b0;
    if (skid_v_q) begin
      if (m_axis_tready) begin
        drain    = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (out_v_q && !m_axis_tready) begin
      if (valid_i) begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else begin
      load_out = 1'b1;
      out_v_d  = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready && valid_i))
    else $error("skid stage filled without a stalled output");

  a_drain_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_v_q) |-> out_v_q && $past(m_axis_tready))
    else $error("skid stage drained without a take");
`endif

endmodule

`default_nettype wire
